@@ hdl/rppr_pkg.sv @@
// Package with the shared widths, sizes and command codes of the reader progress rank block.
`default_nettype none
package rppr_pkg;
    localparam int USER_W    = 16;
    localparam int PAGE_W    = 10;
    localparam int MARK_W    = PAGE_W + 1;
    localparam int CNT_W     = 17;
    localparam int FRAC_W    = 17;
    localparam int USERS     = 1 << USER_W;
    localparam int PAGES     = 1 << PAGE_W;
    localparam int CNT_DEPTH = PAGES + 1;
    localparam int CNT_AW    = $clog2(CNT_DEPTH);
    localparam int DIV_STEPS = CNT_W + 16;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1 << 16);

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
endpackage
`default_nettype wire

@@ hdl/reader_progress_percentile_rank.sv @@
// Top level of the reader progress percentile rank block.
`default_nettype none
// After reset the block clears its user and page count memories and accepts no word in that
// time. A read word updates the count of every page it covers (up to 1024), bounded by one
// pass over the page count memory; a read that does not advance the user's page updates none.
// A query for an unknown user or a sole user is answered without the divider; any other query
// waits for the bit-serial divider. One word is processed at a time; a finished result waits
// in the output register while the next word is accepted.
module reader_progress_percentile_rank (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_cmd,
    input  wire logic [rppr_pkg::USER_W-1:0]  i_user_id,
    input  wire logic [rppr_pkg::PAGE_W-1:0]  i_page,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [rppr_pkg::FRAC_W-1:0]  o_rank_fraction
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MARK  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_LAST  = 3'd4;
    localparam logic [2:0] S_QRD   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0]                     r_state, n_state;
    logic [rppr_pkg::USER_W-1:0]    r_clr, n_clr;
    logic                           r_cmd;
    logic [rppr_pkg::USER_W-1:0]    r_uid;
    logic [rppr_pkg::PAGE_W-1:0]    r_page;
    logic [rppr_pkg::CNT_W-1:0]     r_known, n_known;
    logic [rppr_pkg::CNT_AW-1:0]    r_idx, n_idx;
    logic [rppr_pkg::CNT_AW-1:0]    r_hi, n_hi;
    logic                           r_dec, n_dec;
    logic                           r_wv, n_wv;
    logic [rppr_pkg::CNT_AW-1:0]    r_waddr;
    logic [rppr_pkg::FRAC_W-1:0]    r_res, n_res;
    logic                           r_out_valid;
    logic [rppr_pkg::FRAC_W-1:0]    r_out_data;

    logic                           u_we;
    logic [rppr_pkg::USER_W-1:0]    u_waddr;
    logic [rppr_pkg::MARK_W-1:0]    u_wdata;
    logic [rppr_pkg::MARK_W-1:0]    u_rdata;
    logic                           c_we;
    logic [rppr_pkg::CNT_AW-1:0]    c_waddr;
    logic [rppr_pkg::CNT_W-1:0]     c_wdata;
    logic [rppr_pkg::CNT_AW-1:0]    c_raddr;
    logic [rppr_pkg::CNT_W-1:0]     c_rdata;
    logic                           d_start;
    logic                           d_done;
    logic [rppr_pkg::FRAC_W-1:0]    d_quot;
    logic                           in_acc;
    logic                           out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_RESP) && (!r_out_valid || i_out_ready);

    rppr_ram #(.WIDTH(rppr_pkg::MARK_W), .DEPTH(rppr_pkg::USERS)) u_user_mem (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_raddr (i_user_id),
        .o_rdata (u_rdata)
    );

    rppr_ram #(.WIDTH(rppr_pkg::CNT_W), .DEPTH(rppr_pkg::CNT_DEPTH)) u_count_mem (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    rppr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num   (c_rdata),
        .i_den   (r_known - 1'b1),
        .o_done  (d_done),
        .o_quot  (d_quot)
    );

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_known = r_known;
        n_idx   = r_idx;
        n_hi    = r_hi;
        n_dec   = r_dec;
        n_wv    = 1'b0;
        n_res   = r_res;
        u_we    = 1'b0;
        u_waddr = r_uid;
        u_wdata = {1'b0, r_page} + 1'b1;
        c_we    = r_wv;
        c_waddr = r_waddr;
        c_wdata = r_dec ? (c_rdata - 1'b1) : (c_rdata + 1'b1);
        c_raddr = r_idx;
        d_start = 1'b0;
        case (r_state)
            S_CLEAR: begin
                u_we    = 1'b1;
                u_waddr = r_clr;
                u_wdata = '0;
                c_we    = (r_clr < rppr_pkg::USER_W'(rppr_pkg::CNT_DEPTH));
                c_waddr = r_clr[rppr_pkg::CNT_AW-1:0];
                c_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                if (r_cmd == rppr_pkg::CMD_READ) begin
                    if (u_rdata == '0) begin
                        u_we    = 1'b1;
                        n_known = r_known + 1'b1;
                        n_idx   = {1'b0, r_page} + 1'b1;
                        n_hi    = rppr_pkg::CNT_AW'(rppr_pkg::PAGES);
                        n_dec   = 1'b0;
                        n_state = S_WALK;
                    end else if ({1'b0, r_page} < u_rdata) begin
                        n_state = S_IDLE;
                    end else begin
                        u_we    = 1'b1;
                        n_idx   = u_rdata;
                        n_hi    = {1'b0, r_page};
                        n_dec   = 1'b1;
                        n_state = S_WALK;
                    end
                end else begin
                    c_raddr = u_rdata - 1'b1;
                    if (u_rdata == '0) begin
                        n_res   = '0;
                        n_state = S_RESP;
                    end else if (r_known <= rppr_pkg::CNT_W'(1)) begin
                        n_res   = rppr_pkg::FRAC_ONE;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_QRD;
                    end
                end
            end
            S_WALK: begin
                n_wv = 1'b1;
                if (r_idx == r_hi) begin
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LAST: begin
                n_state = S_IDLE;
            end
            S_QRD: begin
                d_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (d_done) begin
                    n_res   = d_quot;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_known     <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_known <= n_known;
            r_wv    <= n_wv;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_cmd;
            r_uid  <= i_user_id;
            r_page <= i_page;
        end
        r_idx   <= n_idx;
        r_hi    <= n_hi;
        r_dec   <= n_dec;
        r_waddr <= r_idx;
        r_res   <= n_res;
        if (out_load) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_rank_fraction = r_out_data;
endmodule
`default_nettype wire

@@ hdl/rppr_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module rppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hdl/rppr_div.sv @@
// Bit-serial restoring divider for the rank fraction, with the quotient capped at 1.0.
`default_nettype none
module rppr_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rppr_pkg::CNT_W-1:0]  i_num,
    input  wire logic [rppr_pkg::CNT_W-1:0]  i_den,
    output logic                             o_done,
    output logic      [rppr_pkg::FRAC_W-1:0] o_quot
);
    logic                                r_busy;
    logic                                r_done;
    logic [rppr_pkg::DIV_CW-1:0]         r_cnt;
    logic [rppr_pkg::CNT_W-1:0]          r_den;
    logic [rppr_pkg::CNT_W-1:0]          r_rem;
    logic [rppr_pkg::DIV_STEPS-1:0]      r_dvd;
    logic [rppr_pkg::DIV_STEPS-1:0]      r_quot;
    logic [rppr_pkg::CNT_W:0]            n_shift;
    logic [rppr_pkg::CNT_W:0]            n_diff;
    logic                                n_qbit;

    always_comb begin
        n_shift = {r_rem, r_dvd[rppr_pkg::DIV_STEPS-1]};
        n_diff  = n_shift - {1'b0, r_den};
        n_qbit  = (n_shift >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rppr_pkg::DIV_CW'(rppr_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= '0;
            r_dvd  <= {i_num, 16'd0};
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_qbit ? n_diff[rppr_pkg::CNT_W-1:0] : n_shift[rppr_pkg::CNT_W-1:0];
            r_dvd  <= {r_dvd[rppr_pkg::DIV_STEPS-2:0], 1'b0};
            r_quot <= {r_quot[rppr_pkg::DIV_STEPS-2:0], n_qbit};
        end
    end

    always_comb begin
        if ((|r_quot[rppr_pkg::DIV_STEPS-1:rppr_pkg::FRAC_W])
                || (r_quot[rppr_pkg::FRAC_W-1:0] > rppr_pkg::FRAC_ONE)) begin
            o_quot = rppr_pkg::FRAC_ONE;
        end else begin
            o_quot = r_quot[rppr_pkg::FRAC_W-1:0];
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

@@ hdl/rppr_chk.sv @@
// Port checker for the reader progress rank block and its bind to the top level.
`default_nettype none
module rppr_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [rppr_pkg::FRAC_W-1:0]  o_rank_fraction
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rank_fraction))
        else $error("Result word changed or dropped while stalled.");

    a_frac_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_rank_fraction <= rppr_pkg::FRAC_ONE)
        else $error("Rank fraction exceeds one.");

    a_clear_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("Input ready during the clearing pass.");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("A second word was accepted while one is in progress.");
endmodule

bind reader_progress_percentile_rank rppr_chk u_rppr_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_rank_fraction (o_rank_fraction)
);
`default_nettype wire
